// ----- rtl/core/radio_frame_receive_crc_check_top_macros.svh -----
// Assertion helpers for the frame receive block.
// Each expects clk_i and rst_ni in scope.
`ifndef RADIO_FRAME_RECEIVE_CRC_CHECK_TOP_MACROS_SVH
`define RADIO_FRAME_RECEIVE_CRC_CHECK_TOP_MACROS_SVH

// Same-cycle implication.
`define RFCRC_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// Next-cycle implication.
`define RFCRC_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

// ----- rtl/core/rfcrc_pkg.sv -----
`timescale 1ns / 1ps

package rfcrc_pkg;

  // Frame phases
  localparam logic [1:0] PH_LENGTH  = 2'd0;
  localparam logic [1:0] PH_PAYLOAD = 2'd1;
  localparam logic [1:0] PH_CRC_LO  = 2'd2;
  localparam logic [1:0] PH_CRC_HI  = 2'd3;

  // Result kinds
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  // CRC-16 CCITT, MSB first
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_TOP  = 16'h8000;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_start;
  } rx_item_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  payload_byte;
    logic [7:0]  payload_index;
    logic        frame_good;
    logic [7:0]  frame_length;
    logic [15:0] computed_crc;
  } result_t;

  // One byte through the CRC, eight shift steps
  function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] crc;
    logic [15:0] data;
    logic        top;
    crc  = crc_in;
    data = {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      top  = |((crc ^ data) & CRC_TOP);
      crc  = {crc[14:0], 1'b0};
      if (top) begin
        crc = crc ^ CRC_POLY;
      end
      data = {data[14:0], 1'b0};
    end
    return crc;
  endfunction

endpackage

// ----- rtl/core/rfcrc_in_stage.sv -----
`timescale 1ns / 1ps

module rfcrc_in_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  rfcrc_pkg::rx_item_t item_i,
  input  logic               advance_i,
  output logic               valid_o,
  output rfcrc_pkg::rx_item_t item_o
);
  import rfcrc_pkg::*;

  logic     valid_q, valid_d;
  rx_item_t item_q;
  logic     take;

  // Hold off only while a stored request cannot move on
  assign in_stall_o = valid_q & ~advance_i;
  assign take       = in_valid_i & ~in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload register
  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ----- rtl/core/rfcrc_frame.sv -----
`timescale 1ns / 1ps
`include "radio_frame_receive_crc_check_top_macros.svh"

module rfcrc_frame (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  rfcrc_pkg::rx_item_t item_i,
  output logic                has_result_o,
  output rfcrc_pkg::result_t  result_o
);
  import rfcrc_pkg::*;

  logic [1:0]  phase_q, phase_d;
  logic [7:0]  declared_length_q, declared_length_d;
  logic [7:0]  bytes_seen_q, bytes_seen_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  crc_low_q, crc_low_d;

  logic [1:0]  phase_eff;
  logic [15:0] crc_base;
  logic [15:0] crc_next;
  logic [7:0]  seen_inc;
  logic        good;

  // Forced start overrides the current phase
  assign phase_eff = item_i.frame_start ? PH_LENGTH : phase_q;
  assign crc_base  = (phase_eff == PH_LENGTH) ? 16'h0000 : crc_q;
  assign crc_next  = crc_feed(crc_base, item_i.rx_byte);
  assign seen_inc  = bytes_seen_q + 8'd1;
  assign good      = ({item_i.rx_byte, crc_low_q} == crc_q);

  // Next state and result
  always_comb begin
    phase_d           = phase_q;
    declared_length_d = declared_length_q;
    bytes_seen_d      = bytes_seen_q;
    crc_d             = crc_q;
    crc_low_d         = crc_low_q;
    has_result_o      = 1'b0;
    result_o          = '0;
    case (phase_eff)
      PH_LENGTH: begin
        declared_length_d = item_i.rx_byte;
        bytes_seen_d      = 8'd0;
        crc_d             = crc_next;
        crc_low_d         = 8'd0;
        phase_d           = (item_i.rx_byte == 8'd0) ? PH_CRC_LO : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        crc_d                  = crc_next;
        has_result_o           = 1'b1;
        result_o.kind          = KIND_PAYLOAD;
        result_o.payload_byte  = item_i.rx_byte;
        result_o.payload_index = bytes_seen_q;
        bytes_seen_d           = seen_inc;
        if (seen_inc == declared_length_q) begin
          phase_d = PH_CRC_LO;
        end
      end
      PH_CRC_LO: begin
        crc_low_d = item_i.rx_byte;
        phase_d   = PH_CRC_HI;
      end
      PH_CRC_HI: begin
        has_result_o          = 1'b1;
        result_o.kind         = KIND_STATUS;
        result_o.frame_good   = good;
        result_o.frame_length = good ? declared_length_q : 8'd0;
        result_o.computed_crc = crc_q;
        phase_d               = PH_LENGTH;
      end
      default: begin
        phase_d = PH_LENGTH;
      end
    endcase
  end

  // Frame state, updated once per consumed byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q           <= PH_LENGTH;
      declared_length_q <= 8'd0;
      bytes_seen_q      <= 8'd0;
      crc_q             <= 16'h0000;
      crc_low_q         <= 8'd0;
    end else if (step_i) begin
      phase_q           <= phase_d;
      declared_length_q <= declared_length_d;
      bytes_seen_q      <= bytes_seen_d;
      crc_q             <= crc_d;
      crc_low_q         <= crc_low_d;
    end
  end

  // Payload count never reaches the declared length while in payload
  `RFCRC_ASSERT_NOW(a_seen_below_len, phase_q == PH_PAYLOAD,
                    bytes_seen_q < declared_length_q)

  // Zero-length frames never enter the payload phase
  `RFCRC_ASSERT_NEXT(a_zero_len_skips, step_i && phase_eff == PH_LENGTH &&
                     item_i.rx_byte == 8'd0, phase_q == PH_CRC_LO)

endmodule

// ----- rtl/core/rfcrc_out_stage.sv -----
`timescale 1ns / 1ps

module rfcrc_out_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  rfcrc_pkg::result_t result_i,
  output logic               ready_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output rfcrc_pkg::result_t result_o
);
  import rfcrc_pkg::*;

  logic    valid_q, valid_d;
  result_t result_q;

  // Free when empty or draining this cycle
  assign ready_o = ~valid_q | ~out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = result_q;

endmodule

// ----- rtl/core/radio_frame_receive_crc_check_top.sv -----
// Channel | Direction | Handshake            | Payload
// in      | input     | in_valid_i/in_stall_o   | rx_byte_i, frame_start_i
// out     | output    | out_valid_o/out_stall_i | result_kind_o .. computed_crc_o
//
// One byte per cycle sustained while the output is not stalled; a byte is
// registered in the input register, goes through the CRC byte update, and
// its result is registered in the result register.
// Reset (rst_ni low, asynchronous) empties both registers and returns the
// frame state to waiting for a length byte.
// A stalled output holds its result; the input register keeps taking bytes
// that produce no result, and holds the rest until the output frees.
`timescale 1ns / 1ps
`include "radio_frame_receive_crc_check_top_macros.svh"

module radio_frame_receive_crc_check_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  input  logic        frame_start_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        result_kind_o,
  output logic [7:0]  payload_byte_o,
  output logic [7:0]  payload_index_o,
  output logic        frame_good_o,
  output logic [7:0]  frame_length_o,
  output logic [15:0] computed_crc_o
);
  import rfcrc_pkg::*;

  rx_item_t in_item;
  rx_item_t held_item;
  logic     held_valid;
  logic     advance;
  logic     has_result;
  logic     out_ready;
  result_t  next_result;
  result_t  out_result;

  assign in_item.rx_byte     = rx_byte_i;
  assign in_item.frame_start = frame_start_i;

  // A stored byte moves on unless its result has nowhere to go
  assign advance = held_valid & (~has_result | out_ready);

  rfcrc_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .item_i     (in_item),
    .advance_i  (advance),
    .valid_o    (held_valid),
    .item_o     (held_item)
  );

  rfcrc_frame u_frame (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (advance),
    .item_i       (held_item),
    .has_result_o (has_result),
    .result_o     (next_result)
  );

  rfcrc_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance & has_result),
    .result_i    (next_result),
    .ready_o     (out_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (out_result)
  );

  assign result_kind_o   = out_result.kind;
  assign payload_byte_o  = out_result.payload_byte;
  assign payload_index_o = out_result.payload_index;
  assign frame_good_o    = out_result.frame_good;
  assign frame_length_o  = out_result.frame_length;
  assign computed_crc_o  = out_result.computed_crc;

  // Input is only held off while a byte is stored
  `RFCRC_ASSERT_NOW(a_stall_needs_held, in_stall_o, held_valid)

  // A result is never loaded over one still waiting at a stalled output
  `RFCRC_ASSERT_NOW(a_no_overwrite, advance && has_result,
                    !out_valid_o || !out_stall_i)

  // A loaded result shows up as valid next cycle
  `RFCRC_ASSERT_NEXT(a_load_shows, advance && has_result, out_valid_o)

endmodule
